@@ design/ddae_pkg.sv @@
// Shared types, register codes and helpers for the distance-delay ambisonic encoder.
`default_nettype none

package ddae_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W = 15;
	localparam int FRAC_W = 16;
	localparam int GAIN_W = 16;
	localparam int COEF_W = 16;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam int LANES_MAX = 4;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] PREP_LAST = 5'd15;
	localparam logic [CNT_W-1:0] BLEND_LAST = 5'd15;
	localparam logic [CNT_W-1:0] MUL_LAST = 5'd31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DELAY_WHOLE = 4'd0,
		REG_DELAY_FRAC = 4'd1,
		REG_INTERIOR_GAIN = 4'd2,
		REG_EXTERIOR_GAIN = 4'd3,
		REG_COEF_W = 4'd4,
		REG_COEF_X = 4'd5,
		REG_COEF_Y = 4'd6,
		REG_COEF_Z = 4'd7
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_RD_A,
		ST_RD_B,
		ST_LOAD,
		ST_BLEND,
		ST_SUM,
		ST_MUL,
		ST_DONE
	} state_t;

	localparam logic [COEF_W-1:0] COEF_W_RESET = 16'd8192;

	function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [22:0] r);
		logic [SAMPLE_W-1:0] res;
		if (r > 23'sd32767) begin
			res = 16'h7fff;
		end else if (r < -23'sd32768) begin
			res = 16'h8000;
		end else begin
			res = r[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ design/ddae_ram.sv @@
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module ddae_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/distance_delay_ambisonic_encoder.sv @@
// Distance-delay first-order ambisonic encoder with bit-serial arithmetic.
//
//  channel | signals                                     | transfer when
//  --------+---------------------------------------------+----------------------
//  input   | in_valid in_ready sample block_end          | in_valid & in_ready
//  output  | out_valid out_ready out_w..out_z block_end_out | out_valid & out_ready
//  config  | cfg_write cfg_index cfg_data                | cfg_write
//
// After reset all DELAY_DEPTH entries of the delay memory are cleared, one per cycle,
// and no input transfer is taken until the pass is done.
// A sample passes through the delay reduction and gain-coefficient products, the two
// memory reads, the blend, the sum, the channel products, rounding and a return to
// idle; it waits in the done state while the output register is full.
// The channel product loop, one bit of the blended sample per cycle, sets the rate.
// A finished result waits in the output register while the next sample is processed.
`default_nettype none

module distance_delay_ambisonic_encoder #(
	parameter int DELAY_DEPTH = 32768,
	parameter int CHANNELS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [ddae_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [ddae_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [ddae_pkg::SAMPLE_W-1:0] sample,
	input wire logic block_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [ddae_pkg::SAMPLE_W-1:0] out_w,
	output logic signed [ddae_pkg::SAMPLE_W-1:0] out_x,
	output logic signed [ddae_pkg::SAMPLE_W-1:0] out_y,
	output logic signed [ddae_pkg::SAMPLE_W-1:0] out_z,
	output logic block_end_out
);

	import ddae_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [AW:0] DEPTH_C = (AW+1)'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wp_q;
	logic out_valid_q;

	logic [DELAY_W-1:0] delay_whole_q;
	logic [FRAC_W-1:0] delay_frac_q;
	logic [GAIN_W-1:0] interior_gain_q;
	logic [GAIN_W-1:0] exterior_gain_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic block_end_q;
	logic [DELAY_W-1:0] dw_sr_q;
	logic [AW-1:0] rem_q;
	logic [GAIN_W-1:0] ig_sr_q;
	logic [GAIN_W-1:0] eg_sr_q;
	logic [AW-1:0] pos_a_q;
	logic [SAMPLE_W-1:0] a_q;
	logic [SAMPLE_W:0] diff_q;
	logic [FRAC_W-1:0] f_sr_q;
	logic [SAMPLE_W+1:0] bl_hi_q;
	logic [FRAC_W-1:0] bl_lo_q;
	logic [31:0] p_sr_q;

	logic in_xfer;
	logic out_load;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;

	logic [AW:0] mod_t;
	logic [AW-1:0] rem_d;
	logic [AW:0] pos_diff;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] pos_b;
	logic [SAMPLE_W+2:0] bl_s;
	logic [SAMPLE_W-1:0] res [LANES_MAX];

	assign in_xfer = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Remainder of the whole delay by the memory depth, one bit per step.
	always_comb begin
		mod_t = {rem_q, dw_sr_q[DELAY_W-1]};
		if (mod_t >= DEPTH_C) begin
			rem_d = AW'(mod_t - DEPTH_C);
		end else begin
			rem_d = AW'(mod_t);
		end
	end

	always_comb begin
		pos_diff = {1'b0, wp_q} - {1'b0, rem_q};
		if (pos_diff[AW]) begin
			pos_a = AW'(pos_diff + DEPTH_C);
		end else begin
			pos_a = AW'(pos_diff);
		end
		if (pos_a_q == '0) begin
			pos_b = LAST_ADDR;
		end else begin
			pos_b = pos_a_q - AW'(1);
		end
	end

	assign bl_s = {bl_hi_q[SAMPLE_W+1], bl_hi_q}
		+ (f_sr_q[0] ? {{2{diff_q[SAMPLE_W]}}, diff_q} : '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (cnt_q == PREP_LAST) state_d = ST_RD_A;
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_BLEND;
			ST_BLEND: begin
				if (cnt_q == BLEND_LAST) state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == MUL_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = sample_q;
		ram_raddr = pos_b;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_PREP: ram_we = (cnt_q == '0);
			ST_RD_A: ram_raddr = pos_a;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
			wp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_LOAD) wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q <= '0;
			delay_frac_q <= '0;
			interior_gain_q <= '0;
			exterior_gain_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_DELAY_WHOLE) delay_whole_q <= cfg_data[DELAY_W-1:0];
			if (cfg_index == REG_DELAY_FRAC) delay_frac_q <= cfg_data;
			if (cfg_index == REG_INTERIOR_GAIN) interior_gain_q <= cfg_data;
			if (cfg_index == REG_EXTERIOR_GAIN) exterior_gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample;
			block_end_q <= block_end;
			dw_sr_q <= delay_whole_q;
			rem_q <= '0;
			ig_sr_q <= interior_gain_q;
			eg_sr_q <= exterior_gain_q;
		end
		case (state_q)
			ST_PREP: begin
				if (cnt_q < CNT_W'(DELAY_W)) begin
					rem_q <= rem_d;
					dw_sr_q <= {dw_sr_q[DELAY_W-2:0], 1'b0};
				end
				ig_sr_q <= {1'b0, ig_sr_q[GAIN_W-1:1]};
				eg_sr_q <= {1'b0, eg_sr_q[GAIN_W-1:1]};
			end
			ST_RD_A: pos_a_q <= pos_a;
			ST_RD_B: a_q <= ram_rdata;
			ST_LOAD: begin
				diff_q <= {ram_rdata[SAMPLE_W-1], ram_rdata} - {a_q[SAMPLE_W-1], a_q};
				f_sr_q <= delay_frac_q;
				bl_hi_q <= '0;
			end
			ST_BLEND: begin
				bl_hi_q <= bl_s[SAMPLE_W+2:1];
				bl_lo_q <= {bl_s[0], bl_lo_q[FRAC_W-1:1]};
				f_sr_q <= {1'b0, f_sr_q[FRAC_W-1:1]};
			end
			ST_SUM: p_sr_q <= {a_q + bl_hi_q[SAMPLE_W-1:0], bl_lo_q};
			ST_MUL: p_sr_q <= {1'b0, p_sr_q[31:1]};
			default: ;
		endcase
		if (out_load) begin
			out_w <= res[0];
			out_x <= res[1];
			out_y <= res[2];
			out_z <= res[3];
			block_end_out <= block_end_q;
		end
	end

	for (genvar i = 0; i < LANES_MAX; i++) begin : g_lane
		if (i < CHANNELS) begin : g_on
			logic [COEF_W-1:0] coef_q;
			logic [COEF_W:0] gch_q;
			logic [GAIN_W-1:0] gcl_q;
			logic [COEF_W+1:0] gc_s;
			logic [COEF_W+GAIN_W:0] gc;
			logic [COEF_W+GAIN_W+2:0] m_ext;
			logic [COEF_W+GAIN_W+2:0] m_term;
			logic [COEF_W+GAIN_W+2:0] mul_s;
			logic [COEF_W+GAIN_W+1:0] acc_q;
			logic gbit;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q <= (i == 0) ? COEF_W_RESET : '0;
				end else if (cfg_write
					&& cfg_index == CFG_INDEX_W'(int'(REG_COEF_W) + i)) begin
					coef_q <= cfg_data;
				end
			end

			assign gbit = (i == 0) ? ig_sr_q[0] : eg_sr_q[0];
			assign gc_s = {gch_q[COEF_W], gch_q}
				+ (gbit ? {{2{coef_q[COEF_W-1]}}, coef_q} : '0);
			assign gc = {gch_q, gcl_q};
			assign m_ext = {{2{gc[COEF_W+GAIN_W]}}, gc};

			always_comb begin
				if (!p_sr_q[0]) begin
					m_term = '0;
				end else if (cnt_q == MUL_LAST) begin
					m_term = -m_ext;
				end else begin
					m_term = m_ext;
				end
			end

			assign mul_s = {acc_q[COEF_W+GAIN_W+1], acc_q} + m_term;

			always_ff @(posedge clk) begin
				if (in_xfer) gch_q <= '0;
				if (state_q == ST_PREP) begin
					gch_q <= gc_s[COEF_W+1:1];
					gcl_q <= {gc_s[0], gcl_q[GAIN_W-1:1]};
				end
				if (state_q == ST_SUM) acc_q <= '0;
				if (state_q == ST_MUL) acc_q <= mul_s[COEF_W+GAIN_W+2:1];
			end

			assign res[i] = sat16(signed'({acc_q[33], acc_q[33:12]} + 23'(acc_q[11])));
		end else begin : g_off
			assign res[i] = '0;
		end
	end

	ddae_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DELAY_DEPTH)
	) u_delay_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_PREP)
		else $error("Accepted sample did not start processing.");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("Input taken during memory clearing.");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_A |-> {1'b0, rem_q} < DEPTH_C)
		else $error("Reduced delay is not below the memory depth.");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> state_q == ST_DONE)
		else $error("Result lost while the output register was full.");

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> wp_q != $past(wp_q))
		else $error("Write position did not advance.");
`endif

endmodule

`default_nettype wire
